// ----- src/oat_pkg.sv -----
package oat_pkg;

  // default list capacity
  localparam int unsigned CAPACITY_DEF = 16;

  // fixed field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned FIDX_W  = 4;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND  = 3'd0,
    K_INSERT  = 3'd1,
    K_DROP    = 3'd2,
    K_REMOVE  = 3'd3,
    K_FIND    = 3'd4,
    K_REPLACE = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // what the sequencer has to do for a request
  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_INSERT,
    OP_DROP,
    OP_REMOVE,
    OP_SEARCH
  } op_e;

  typedef struct packed {
    status_e status;
    op_e     op;
  } dec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_SRC_RD,
    S_SRC_CMP,
    S_FIN
  } state_e;

endpackage

// ----- src/oat_check.sv -----
module oat_check #(
  parameter int unsigned CAPACITY = oat_pkg::CAPACITY_DEF,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic [oat_pkg::KIND_W-1:0] kind_i,
  input  logic [oat_pkg::POS_W-1:0]  position_i,
  input  logic [CW-1:0]              count_i,
  output oat_pkg::dec_t              dec_o
);
  import oat_pkg::*;

  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic          full;
  logic          empty;
  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic          ins_ok;
  logic          rem_ok;

  assign full   = (count_i == CW'(CAPACITY));
  assign empty  = (count_i == '0);
  assign pos_w  = PW'(position_i);
  assign cnt_w  = PW'(count_i);
  // insert may land one past the last entry, remove only on an entry
  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign rem_ok = (pos_w != '0) && (pos_w <= cnt_w);

  always_comb begin
    dec_o.status = ST_OK;
    dec_o.op     = OP_NONE;
    case (kind_i)
      K_APPEND: begin
        if (full) dec_o.status = ST_FULL;
        else      dec_o.op     = OP_APPEND;
      end
      K_INSERT: begin
        if (full)         dec_o.status = ST_FULL;
        else if (!ins_ok) dec_o.status = ST_BADPOS;
        else              dec_o.op     = OP_INSERT;
      end
      K_DROP: begin
        if (empty) dec_o.status = ST_EMPTY;
        else       dec_o.op     = OP_DROP;
      end
      K_REMOVE: begin
        if (empty)        dec_o.status = ST_EMPTY;
        else if (!rem_ok) dec_o.status = ST_BADPOS;
        else              dec_o.op     = OP_REMOVE;
      end
      K_FIND, K_REPLACE: begin
        dec_o.op = OP_SEARCH;
      end
      default: begin
        dec_o.op = OP_NONE;
      end
    endcase
  end

endmodule

// ----- src/ordered_array_table.sv -----
// ordered_array_table: fixed-capacity list of signed 32-bit words with a count
//
// input channel (in_valid_i / in_ready_o) carries one request: kind, 1-based
// position, item value and replacement value. output channel (out_valid_o /
// out_ready_i) returns exactly one result per request: status, index of the
// first match and the entry count after the operation.
// entries live in one synchronous single-port-read memory with a registered read.
// one request is worked on at a time; in_ready_o is high only when idle.
// work up to the result register:
//   append, drop last, errors, unused kinds: finished straight from idle
//   insert at slot p: one read/write pair per entry at or above p, then the new item
//   remove at slot p: one read/write pair per entry above p
//   find/replace: one read and one compare per entry up to the first match or the end
// appends and drops run one per cycle while the output is free; any other request
// holds the block until it is through, paced by the single memory read port.
// a finished result waits in a holding stage while the output still holds an untaken
// result; the sequencer takes no new request until that result moves to the output.
// reset clears the count and the control state; memory contents are left as
// they are, since only entries below the count are ever read.
module ordered_array_table #(
  parameter int unsigned CAPACITY = oat_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [oat_pkg::KIND_W-1:0]        kind_i,
  input  logic [oat_pkg::POS_W-1:0]         position_i,
  input  logic signed [oat_pkg::DATA_W-1:0] item_value_i,
  input  logic signed [oat_pkg::DATA_W-1:0] new_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [oat_pkg::STAT_W-1:0]        status_o,
  output logic [oat_pkg::FIDX_W-1:0]        found_index_o,
  output logic [oat_pkg::CNT_W-1:0]         entry_count_o
);
  import oat_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  // sequencer state
  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] k_q, k_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] nval_q, nval_d;
  logic repl_q, repl_d;

  // holding stage for a result that finds the output busy
  status_e res_status_q, res_status_d;
  logic [FIDX_W-1:0] res_fidx_q, res_fidx_d;
  logic [CNT_W-1:0] res_count_q, res_count_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [FIDX_W-1:0] out_fidx_q, out_fidx_d;
  logic [CNT_W-1:0] out_count_q, out_count_d;

  // entry memory
  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rdata_q;
  logic mem_we;
  logic mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  // request decode
  dec_t dec;
  logic accept;
  logic out_free;
  logic [PW-1:0] pos_m1;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic at_k;
  logic rem_last;
  logic src_end;
  logic src_hit;

  // finishing result for this cycle
  logic fin;
  status_e fin_status;
  logic [FIDX_W-1:0] fin_fidx;
  logic [CW+CNT_W-1:0] cnt_ext;
  logic [CW+FIDX_W-1:0] idx_ext;

  oat_check #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_check (
    .kind_i     (kind_i),
    .position_i (position_i),
    .count_i    (count_q),
    .dec_o      (dec)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // the output register can take a new result this cycle
  assign out_free   = !out_valid_q || out_ready_i;

  assign pos_m1   = PW'(position_i) - PW'(1);
  assign idx_inc  = idx_q + CW'(1);
  assign idx_dec  = idx_q - CW'(1);
  assign at_k     = (idx_q == k_q);
  assign rem_last = (idx_inc == count_q);
  assign src_end  = (idx_q == count_q);
  assign src_hit  = (rdata_q == val_q);

  assign cnt_ext = {{CNT_W{1'b0}}, count_d};
  assign idx_ext = {{FIDX_W{1'b0}}, idx_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (dec.op)
            OP_INSERT: state_d = S_INS_RD;
            OP_REMOVE: state_d = S_REM_RD;
            OP_SEARCH: state_d = S_SRC_RD;
            default:   state_d = out_free ? S_IDLE : S_FIN;
          endcase
        end
      end
      S_INS_RD: begin
        if (at_k) state_d = out_free ? S_IDLE : S_FIN;
        else      state_d = S_INS_WR;
      end
      S_INS_WR: state_d = S_INS_RD;
      S_REM_RD: begin
        if (rem_last) state_d = out_free ? S_IDLE : S_FIN;
        else          state_d = S_REM_WR;
      end
      S_REM_WR: state_d = S_REM_RD;
      S_SRC_RD: begin
        if (src_end) state_d = out_free ? S_IDLE : S_FIN;
        else         state_d = S_SRC_CMP;
      end
      S_SRC_CMP: begin
        if (src_hit) state_d = out_free ? S_IDLE : S_FIN;
        else         state_d = S_SRC_RD;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    k_d          = k_q;
    val_d        = val_q;
    nval_d       = nval_q;
    repl_d       = repl_q;
    res_status_d = res_status_q;
    res_fidx_d   = res_fidx_q;
    res_count_d  = res_count_q;
    out_status_d = out_status_q;
    out_fidx_d   = out_fidx_q;
    out_count_d  = out_count_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = idx_q[AW-1:0];
    mem_raddr    = idx_q[AW-1:0];
    mem_wdata    = rdata_q;
    fin          = 1'b0;
    fin_status   = ST_OK;
    fin_fidx     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d      = item_value_i;
          nval_d     = new_value_i;
          repl_d     = (kind_i == K_REPLACE);
          k_d        = pos_m1[CW-1:0];
          fin_status = dec.status;
          case (dec.op)
            OP_APPEND: begin
              // count is below capacity here, so it fits the address
              mem_we    = 1'b1;
              mem_waddr = count_q[AW-1:0];
              mem_wdata = item_value_i;
              count_d   = count_q + CW'(1);
              fin       = 1'b1;
            end
            OP_DROP: begin
              count_d = count_q - CW'(1);
              fin     = 1'b1;
            end
            OP_INSERT: idx_d = count_q;
            OP_REMOVE: idx_d = pos_m1[CW-1:0];
            OP_SEARCH: idx_d = '0;
            default:   fin   = 1'b1;
          endcase
        end
      end
      S_INS_RD: begin
        if (at_k) begin
          // every entry above the slot has moved up
          mem_we    = 1'b1;
          mem_waddr = k_q[AW-1:0];
          mem_wdata = val_q;
          count_d   = count_q + CW'(1);
          fin       = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_dec;
      end
      S_REM_RD: begin
        if (rem_last) begin
          count_d = count_q - CW'(1);
          fin     = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
        end
      end
      S_REM_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_inc;
      end
      S_SRC_RD: begin
        if (src_end) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
        end else begin
          mem_re = 1'b1;
        end
      end
      S_SRC_CMP: begin
        if (src_hit) begin
          fin       = 1'b1;
          fin_fidx  = idx_ext[FIDX_W-1:0];
          mem_we    = repl_q;
          mem_wdata = nval_q;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_fidx_d   = res_fidx_q;
          out_count_d  = res_count_q;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase

    // a finished result goes straight out, or waits in the holding stage
    if (fin) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_status_d = fin_status;
        out_fidx_d   = fin_fidx;
        out_count_d  = cnt_ext[CNT_W-1:0];
      end else begin
        res_status_d = fin_status;
        res_fidx_d   = fin_fidx;
        res_count_d  = cnt_ext[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    k_q          <= k_d;
    val_q        <= val_d;
    nval_q       <= nval_d;
    repl_q       <= repl_d;
    res_status_q <= res_status_d;
    res_fidx_q   <= res_fidx_d;
    res_count_q  <= res_count_d;
    out_status_q <= out_status_d;
    out_fidx_q   <= out_fidx_d;
    out_count_q  <= out_count_d;
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_index_o = out_fidx_q;
  assign entry_count_o = out_count_q;

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a scan leaves the count alone
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRC_RD || state_q == S_SRC_CMP) |=> $stable(count_q))
    else $error("count changed during search");

  // the memory never reads and writes one entry in the same cycle
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write collide on one entry");

  // a held result stays held while the output is stalled
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN))
    else $error("held result dropped during stall");

endmodule

// ----- sim/ordered_array_table_tb.sv -----
module ordered_array_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oat_pkg::*;

  localparam int unsigned DEPTH       = CAPACITY_DEF;
  localparam int unsigned RANDOM_OPS  = 1900;
  localparam int unsigned LONG_HOLD   = 400;   // receiver hold-off in the backpressure test
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int unsigned TAIL_CYCLES = 40;    // longer than the slowest insert

  // kinds the block treats as no-ops
  localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  // one result as the block should return it
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] found_index;
    logic [CNT_W-1:0]  entry_count;
  } list_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [KIND_W-1:0]        kind_i;
  logic [POS_W-1:0]         position_i;
  logic signed [DATA_W-1:0] item_value_i;
  logic signed [DATA_W-1:0] new_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [STAT_W-1:0]        status_o;
  logic [FIDX_W-1:0]        found_index_o;
  logic [CNT_W-1:0]         entry_count_o;

  // shadow copy of the list contents and its length
  logic [DATA_W-1:0] shadow_words [DEPTH];
  int                shadow_len;

  // results still owed by the block, oldest first
  list_result_t pending_results [$];

  int mismatch_count  = 0;
  int burst_left      = 0;
  int hold_off_cycles = 0;
  int fill_target     = 8;
  int idle_cycles     = 0;

  rx_mode_e rx_mode  = RX_FREE;
  int       rx_left  = 0;
  int       rx_phase = 0;

  ordered_array_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .new_value_i   (new_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .entry_count_o (entry_count_o)
  );

  always #4 clk_i = ~clk_i;

  // apply one request to the shadow list and return what the block should answer
  function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] kind,
                                                 input logic [POS_W-1:0]  pos,
                                                 input logic [DATA_W-1:0] value,
                                                 input logic [DATA_W-1:0] repl);
    list_result_t res;
    int p;
    int hit;
    res.status      = ST_OK;
    res.found_index = '0;
    p               = int'(pos);
    hit             = -1;
    case (kind)
      K_APPEND: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_len] = value;
          shadow_len++;
        end
      end
      K_INSERT: begin
        // full wins over a bad position
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else if (p < 1 || p > shadow_len + 1) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = shadow_len; i >= p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p-1] = value;
          shadow_len++;
        end
      end
      K_DROP: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_len--;
          shadow_words[shadow_len] = '0;
        end
      end
      K_REMOVE: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p < 1 || p > shadow_len) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = p; i < shadow_len; i++) shadow_words[i-1] = shadow_words[i];
          shadow_len--;
          shadow_words[shadow_len] = '0;
        end
      end
      K_FIND, K_REPLACE: begin
        // lowest matching index among the live entries
        for (int i = 0; i < shadow_len && hit < 0; i++) begin
          if (shadow_words[i] == value) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.found_index = hit[FIDX_W-1:0];
          if (kind == K_REPLACE) shadow_words[hit] = repl;
        end
      end
      default: begin
        // spare kinds leave everything alone
      end
    endcase
    res.entry_count = shadow_len[CNT_W-1:0];
    return res;
  endfunction

  // offer one request, wait for the handshake, then log what should come back
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] repl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // often no gap at all, so bursts run back to back
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    position_i   <= pos;
    item_value_i <= value;
    new_value_i  <= repl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.insert(pending_results.size(), apply_list_op(kind, pos, value, repl));
  endtask

  // stop offering until the block has answered everything
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // values drawn from a small pool so that duplicates and extremes show up
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      4, 5, 6: return DATA_W'($urandom_range(1, 6));
      default: return $urandom;
    endcase
  endfunction

  // one random request, steered toward fill_target so the list visits both ends
  task automatic send_random_op();
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] repl;
    int roll;
    int grow_pct;
    int shrink_pct;
    grow_pct   = (shadow_len < fill_target) ? 60 : 15;
    shrink_pct = (shadow_len > fill_target) ? 60 : 15;
    roll       = $urandom_range(0, 99);
    if (roll < 4) begin
      kind = $urandom_range(0, 1) ? K_SPARE_LO : K_SPARE_HI;
    end else if (roll < 4 + grow_pct) begin
      kind = $urandom_range(0, 1) ? K_APPEND : K_INSERT;
    end else if (roll < 4 + grow_pct + shrink_pct) begin
      kind = $urandom_range(0, 1) ? K_DROP : K_REMOVE;
    end else begin
      kind = $urandom_range(0, 1) ? K_FIND : K_REPLACE;
    end

    // mostly legal positions, the rest anywhere in the field
    pos = POS_W'($urandom_range(0, 31));
    if ($urandom_range(0, 4) != 0) begin
      if (kind == K_INSERT) pos = POS_W'($urandom_range(1, shadow_len + 1));
      else if (kind == K_REMOVE && shadow_len > 0) pos = POS_W'($urandom_range(1, shadow_len));
    end

    value = pick_value();
    // searches mostly look for something that is there
    if ((kind == K_FIND || kind == K_REPLACE) && shadow_len > 0 && $urandom_range(0, 4) < 3)
      value = shadow_words[$urandom_range(0, shadow_len - 1)];
    repl = $urandom_range(0, 1) ? pick_value() : $urandom;
    send_request(kind, pos, value, repl);
  endtask

  task automatic test_empty_list();
    send_request(K_DROP,    5'd1,  32'h0000_0001, 32'h0);
    send_request(K_REMOVE,  5'd1,  32'h0000_0001, 32'h0);
    send_request(K_FIND,    5'd0,  32'h0000_0000, 32'h0);
    send_request(K_REPLACE, 5'd0,  32'h0000_0000, 32'hffff_ffff);
    send_request(K_INSERT,  5'd0,  32'h0000_0007, 32'h0);
    send_request(K_INSERT,  5'd2,  32'h0000_0007, 32'h0);
  endtask

  task automatic test_positions();
    send_request(K_INSERT, 5'd1,  32'h8000_0000, 32'h0);
    send_request(K_APPEND, 5'd0,  32'h7fff_ffff, 32'h0);
    // insert right past the top, then in the middle
    send_request(K_INSERT, 5'd3,  32'h0000_0000, 32'h0);
    send_request(K_INSERT, 5'd2,  32'hffff_ffff, 32'h0);
    // one past the count, zero, and the top of the field are all refused
    send_request(K_REMOVE, 5'd5,  32'h0,         32'h0);
    send_request(K_REMOVE, 5'd0,  32'h0,         32'h0);
    send_request(K_REMOVE, 5'd31, 32'h0,         32'h0);
    send_request(K_REMOVE, 5'd1,  32'h0,         32'h0);
    send_request(K_REMOVE, 5'd3,  32'h0,         32'h0);
  endtask

  task automatic test_find_replace();
    send_request(K_FIND,    5'd0, 32'hffff_ffff, 32'h0);
    send_request(K_REPLACE, 5'd0, 32'h7fff_ffff, 32'h8000_0000);
    // the replaced value is found in its new slot
    send_request(K_FIND,    5'd0, 32'h8000_0000, 32'h0);
    send_request(K_FIND,    5'd0, 32'h0000_3039, 32'h0);
  endtask

  task automatic test_unused_kinds();
    send_request(K_SPARE_LO, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
    send_request(K_SPARE_HI, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  // receiver holds off while the list is filled to capacity, then the full cases
  task automatic test_full_under_backpressure();
    hold_off_cycles = LONG_HOLD;
    while (shadow_len < DEPTH - 1) send_request(K_APPEND, 5'd0, pick_value(), 32'h0);
    send_request(K_INSERT, POS_W'(DEPTH + 1), 32'h5a5a_c3c3, 32'h0);
    send_request(K_APPEND, 5'd1, 32'h0000_0001, 32'h0);
    // full is reported ahead of the bad position
    send_request(K_INSERT, 5'd0, 32'h0000_0001, 32'h0);
    send_request(K_FIND,   5'd0, 32'h5a5a_c3c3, 32'h0);
    send_request(K_REMOVE, POS_W'(DEPTH),     32'h0, 32'h0);
    send_request(K_REMOVE, POS_W'(DEPTH + 1), 32'h0, 32'h0);
  endtask

  // sender goes quiet until every answer is in, several times over
  task automatic test_drain_pauses();
    repeat (4) begin
      repeat (15) send_random_op();
      wait_until_drained();
    end
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 120 == 0) begin
        case ($urandom_range(0, 3))
          0:       fill_target = 0;
          1:       fill_target = DEPTH;
          default: fill_target = $urandom_range(0, DEPTH);
        endcase
      end
      send_random_op();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : check_result
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status=%0d found_index=%0d entry_count=%0d",
                   status_o, found_index_o, entry_count_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || found_index_o !== want.found_index ||
            entry_count_o !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status=%0d found_index=%0d entry_count=%0d, got %0d %0d %0d",
                     want.status, want.found_index, want.entry_count,
                     status_o, found_index_o, entry_count_o);
        end
      end
    end
  end

  // receiver: shifting stall patterns, plus a long hold-off on request
  always @(posedge clk_i) begin : drive_out_ready
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_FREE:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= ((rx_phase % 5) < 2);
      endcase
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ordered_array_table_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = '0;
    position_i   = '0;
    item_value_i = '0;
    new_value_i  = '0;
    out_ready_i  = 1'b0;
    shadow_len   = 0;
    for (int i = 0; i < DEPTH; i++) shadow_words[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_positions();
    test_find_replace();
    test_unused_kinds();
    test_full_under_backpressure();
    test_drain_pauses();
    test_random_mix();

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("ordered_array_table_tb: clean");
    end else begin
      $display("ordered_array_table_tb: errors");
    end
    $finish;
  end

endmodule

// ----- ordered_array_table.f -----
src/oat_pkg.sv
src/oat_check.sv
src/ordered_array_table.sv
sim/ordered_array_table_tb.sv
